// ===== src/fcis_pkg.sv =====
package fcis_pkg;

  // Table geometry
  localparam int SLOTS    = 16;
  localparam int ID_WIDTH = 16;

  // Stored id width: ids are 16-bit fields, masked to ID_WIDTH
  localparam int IDW   = (ID_WIDTH < 16) ? ID_WIDTH : 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // Word layout
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Operation codes
  localparam logic [2:0] FN_ADD      = 3'd0;
  localparam logic [2:0] FN_REMOVE   = 3'd1;
  localparam logic [2:0] FN_CONTAINS = 3'd2;
  localparam logic [2:0] FN_FIRST    = 3'd3;
  localparam logic [2:0] FN_LIST     = 3'd4;

endpackage

// ===== src/fixed_capacity_id_set.sv =====
// Channel  Dir  Ports                       Contents
// in       in   in_tvalid/in_tready         tdata: id[15:0], list_limit[20:16]
//                                           tuser: func[2:0]
// out      out  out_tvalid/out_tready       tdata: id_out[15:0], count[20:16],
//                                           full_res[21], empty_res[22]
//                                           tuser: status[0], found[1]
//                                           tlast: last result of a request
//
// Each request scans all SLOTS slots through one memory read port and one
// id comparator, one slot per cycle while the output is not stalled. A
// request goes through the slot reads, the compare of the last slot, a drain
// step, the result step and the idle state that takes the next word.
// in_tready is high only while idle. A list request emits one word per used
// slot, up to its limit; the scan holds while the output register is full
// and not taken.
// Synchronous active-low reset empties the table at once (valid bits clear).
module fixed_capacity_id_set (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fcis_pkg::IN_DATA_W-1:0]      in_tdata,   // id[15:0], list_limit[20:16]
  input  logic [2:0]                          in_tuser,   // func[2:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fcis_pkg::OUT_DATA_W-1:0]     out_tdata,  // id_out, count, full, empty
  output logic [1:0]                          out_tuser,  // status, found
  output logic                                out_tlast
);
  import fcis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r;

  // Request registers
  logic [2:0]         func_r;
  logic [IDW-1:0]     id_r;
  logic [4:0]         total_r;      // list length, min(count, limit)

  // Table
  logic [IDW-1:0]     mem [SLOTS];
  logic [SLOTS-1:0]   used_r;
  logic [CNT_W-1:0]   count_r;

  // Scan pipeline: address stage, then data stage
  logic [IDX_W:0]     idx_r;
  logic               b_vld_r;
  logic [IDX_W-1:0]   b_idx_r;
  logic               b_used_r;
  logic [IDW-1:0]     rd_data_r;

  // Scan results
  logic               match_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               first_found_r;
  logic [IDW-1:0]     first_val_r;
  logic [4:0]         n_r;

  // Output register
  logic               out_valid_r;
  logic               o_status_r;
  logic               o_found_r;
  logic [IDW-1:0]     o_id_r;
  logic [4:0]         o_count_r;
  logic               o_full_r;
  logic               o_empty_r;
  logic               o_last_r;

  logic               accept;
  logic               step_ok;
  logic               rd_en;
  logic               hit;
  logic               id_nz;
  logic               is_full;
  logic               emit;
  logic               e_status;
  logic               e_found;
  logic [IDW-1:0]     e_id;
  logic               e_last;
  logic               do_add;
  logic               do_remove;
  logic [CNT_W-1:0]   count_nxt;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   lim_ext;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign step_ok   = !out_valid_r || out_tready;
  assign rd_en     = (state_r == ST_SCAN) && step_ok && (idx_r < (IDX_W+1)'(SLOTS));
  assign hit       = b_used_r && (rd_data_r == id_r);
  assign id_nz     = (id_r != '0);
  assign is_full   = (count_r == CNT_W'(SLOTS));

  assign cnt_ext = CMP_W'(count_r);
  assign lim_ext = CMP_W'(in_tdata[20:16]);

  // Result selection: list words during the scan, else one word at the end
  always_comb begin
    emit      = 1'b0;
    e_status  = 1'b0;
    e_found   = 1'b0;
    e_id      = '0;
    e_last    = 1'b1;
    do_add    = 1'b0;
    do_remove = 1'b0;
    count_nxt = count_r;
    if (state_r == ST_SCAN) begin
      if (step_ok && b_vld_r && func_r == FN_LIST && b_used_r && n_r < total_r) begin
        emit    = 1'b1;
        e_found = 1'b1;
        e_id    = rd_data_r;
        e_last  = (5'(n_r + 5'd1) == total_r);
      end
    end else if (state_r == ST_DONE && step_ok) begin
      emit = 1'b1;
      case (func_r)
        FN_ADD: begin
          if (!id_nz || is_full || match_r || !free_found_r) begin
            e_status = 1'b1;
          end else begin
            do_add    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        FN_REMOVE: begin
          if (!id_nz || !match_r) begin
            e_status = 1'b1;
          end else begin
            do_remove = 1'b1;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        FN_CONTAINS: e_found = id_nz && match_r;
        FN_FIRST: begin
          e_found = first_found_r;
          e_id    = first_found_r ? first_val_r : '0;
        end
        FN_LIST: emit = (total_r == 5'd0);   // empty list: one word
        default: e_status = 1'b1;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      used_r        <= '0;
      count_r       <= '0;
      b_vld_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      match_r       <= 1'b0;
      free_found_r  <= 1'b0;
      first_found_r <= 1'b0;
      n_r           <= '0;
      idx_r         <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r       <= ST_SCAN;
            idx_r         <= '0;
            b_vld_r       <= 1'b0;
            match_r       <= 1'b0;
            free_found_r  <= 1'b0;
            first_found_r <= 1'b0;
            n_r           <= '0;
          end
        end
        ST_SCAN: begin
          if (step_ok) begin
            if (b_vld_r) begin
              if (hit && !match_r) begin
                match_r <= 1'b1;
              end
              if (!b_used_r && !free_found_r) begin
                free_found_r <= 1'b1;
              end
              if (b_used_r && !first_found_r) begin
                first_found_r <= 1'b1;
              end
              if (emit) begin
                n_r <= n_r + 5'd1;
              end
            end
            if (rd_en) begin
              idx_r   <= idx_r + 1'b1;
              b_vld_r <= 1'b1;
            end else begin
              b_vld_r <= 1'b0;
              if (!b_vld_r) begin
                state_r <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (step_ok) begin
            state_r <= ST_IDLE;
            count_r <= count_nxt;
            if (do_add) begin
              used_r[free_idx_r] <= 1'b1;
            end
            if (do_remove) begin
              used_r[match_idx_r] <= 1'b0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_tuser;
      id_r    <= in_tdata[IDW-1:0];
      total_r <= (cnt_ext < lim_ext) ? 5'(cnt_ext) : in_tdata[20:16];
    end
    if (rd_en) begin
      b_idx_r  <= idx_r[IDX_W-1:0];
      b_used_r <= used_r[idx_r[IDX_W-1:0]];
    end
    if (state_r == ST_SCAN && step_ok && b_vld_r) begin
      if (hit && !match_r) begin
        match_idx_r <= b_idx_r;
      end
      if (!b_used_r && !free_found_r) begin
        free_idx_r <= b_idx_r;
      end
      if (b_used_r && !first_found_r) begin
        first_val_r <= rd_data_r;
      end
    end
    if (emit) begin
      o_status_r <= e_status;
      o_found_r  <= e_found;
      o_id_r     <= e_id;
      o_count_r  <= 5'(count_nxt);
      o_full_r   <= (count_nxt == CNT_W'(SLOTS));
      o_empty_r  <= (count_nxt == '0);
      o_last_r   <= e_last;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[free_idx_r] <= id_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_empty_r, o_full_r, o_count_r, 16'(o_id_r)};
  assign out_tuser  = {o_found_r, o_status_r};
  assign out_tlast  = o_last_r;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcis_pkg::*;

  // Operation codes the block does not define; each one must come back as a
  // single error word with the table untouched.
  localparam logic [2:0] FN_RSVD_LO = 3'd5;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;

  // Only the low ID_WIDTH bits of an id take part in matching and storage.
  localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_WIDTH) - 64'd1);

  localparam int POOL_SIZE  = 24;   // distinct ids reused so hits and dups are common
  localparam int TAIL_ITEMS = 30;   // final stretch is driven with no idling
  localparam int DRAIN_WAIT = 2 * SLOTS + 8;

  // One request word as it goes into the block.
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] id;
    logic [4:0]  limit;
  } set_req_t;

  // One reply word, unpacked from out_tdata / out_tuser / out_tlast.
  typedef struct packed {
    logic        status;
    logic        found;
    logic [15:0] id_out;
    logic [4:0]  count;
    logic        full;
    logic        empty;
    logic        last;
  } set_reply_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;   // id[15:0], list_limit[20:16]
  logic [2:0]             in_tuser   = '0;   // func[2:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;         // id_out[15:0], count[20:16], full[21], empty[22]
  logic [1:0]             out_tuser;         // status[0], found[1]
  logic                   out_tlast;

  fixed_capacity_id_set dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------
  // Shadow of the id table, updated when a request word is accepted.
  // ---------------------------------------------------------------------
  logic [15:0] shadow_id   [SLOTS];
  logic        shadow_busy [SLOTS];
  int          shadow_count = 0;

  set_req_t    pending_requests [$];   // words still to be driven
  set_reply_t  expected_replies [$];   // reply words owed by the block

  int n_planned    = 0;
  int n_accepted   = 0;
  int n_replies    = 0;
  int n_list_words = 0;
  int n_full_hits  = 0;
  int n_refused    = 0;
  int mismatches   = 0;

  // Slot that holds id, or -1.
  function automatic int slot_holding(input logic [15:0] key);
    int hit;
    hit = -1;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (shadow_busy[i] && shadow_id[i] == key) hit = i;
    return hit;
  endfunction

  // Reply word with count and flags as they stand now.
  function automatic set_reply_t reply_now(input logic status, input logic found,
                                           input logic [15:0] id_out, input logic last);
    set_reply_t r;
    r.status = status;
    r.found  = found;
    r.id_out = id_out;
    r.count  = 5'(shadow_count);
    r.full   = (shadow_count >= SLOTS);
    r.empty  = (shadow_count == 0);
    r.last   = last;
    return r;
  endfunction

  // Set semantics: update the shadow table and queue the reply words.
  task automatic apply_set_op(input set_req_t rq);
    logic [15:0] key;
    int          hit;
    int          free_slot;
    int          total;
    int          n;
    key = rq.id & ID_MASK;
    hit = slot_holding(key);
    case (rq.op)
      FN_ADD: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!shadow_busy[i]) free_slot = i;
        if (key == '0 || shadow_count >= SLOTS || hit >= 0 || free_slot < 0) begin
          n_refused++;
          expected_replies.push_back(reply_now(1'b1, 1'b0, '0, 1'b1));
        end else begin
          shadow_busy[free_slot] = 1'b1;
          shadow_id[free_slot]   = key;
          shadow_count++;
          if (shadow_count == SLOTS) n_full_hits++;
          expected_replies.push_back(reply_now(1'b0, 1'b0, '0, 1'b1));
        end
      end
      FN_REMOVE: begin
        // Removing the empty id is refused even though no slot is "used" by it.
        if (key == '0 || hit < 0) begin
          n_refused++;
          expected_replies.push_back(reply_now(1'b1, 1'b0, '0, 1'b1));
        end else begin
          shadow_busy[hit] = 1'b0;
          shadow_id[hit]   = '0;
          if (shadow_count > 0) shadow_count--;
          expected_replies.push_back(reply_now(1'b0, 1'b0, '0, 1'b1));
        end
      end
      FN_CONTAINS:
        expected_replies.push_back(reply_now(1'b0, key != '0 && hit >= 0, '0, 1'b1));
      FN_FIRST: begin
        hit = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (shadow_busy[i]) hit = i;
        if (hit >= 0) expected_replies.push_back(reply_now(1'b0, 1'b1, shadow_id[hit], 1'b1));
        else          expected_replies.push_back(reply_now(1'b0, 1'b0, '0, 1'b1));
      end
      FN_LIST: begin
        total = shadow_count;
        if (total > int'(rq.limit)) total = int'(rq.limit);
        if (total > SLOTS) total = SLOTS;
        if (total == 0) begin
          // nothing to list: one empty word that closes the request
          expected_replies.push_back(reply_now(1'b0, 1'b0, '0, 1'b1));
        end else begin
          n = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (shadow_busy[i] && n < total) begin
              expected_replies.push_back(reply_now(1'b0, 1'b1, shadow_id[i], n + 1 == total));
              n++;
            end
          end
        end
      end
      default: begin
        n_refused++;
        expected_replies.push_back(reply_now(1'b1, 1'b0, '0, 1'b1));
      end
    endcase
  endtask

  // No idling on either side once the backlog is short.
  function automatic bit in_tail();
    return pending_requests.size() < TAIL_ITEMS;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  logic [15:0] id_pool [POOL_SIZE];

  task automatic queue_req(input logic [2:0] op, input logic [15:0] id, input logic [4:0] limit);
    set_req_t rq;
    rq.op    = op;
    rq.id    = id;
    rq.limit = limit;
    pending_requests.push_back(rq);
  endtask

  // Mostly pool ids; now and then the empty id or any 16-bit value.
  function automatic logic [15:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 88) return '0;
    return 16'($urandom);
  endfunction

  // Limits mostly within the table size, sometimes past it.
  function automatic logic [4:0] pick_limit();
    if ($urandom_range(0, 99) < 70) return 5'($urandom_range(0, SLOTS));
    return 5'($urandom_range(0, 31));
  endfunction

  // Pool ids in random order.
  task automatic shuffled_pool(output logic [15:0] order [POOL_SIZE]);
    logic [15:0] tmp;
    int          j;
    for (int i = 0; i < POOL_SIZE; i++) order[i] = id_pool[i];
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
  endtask

  task automatic fill_episode();
    logic [15:0] order [POOL_SIZE];
    shuffled_pool(order);
    for (int i = 0; i < SLOTS + 2; i++) queue_req(FN_ADD, order[i], pick_limit());
    queue_req(FN_ADD, 16'($urandom_range(1, 65535)), pick_limit());  // into a full table
    queue_req(FN_LIST, '0, 5'(SLOTS));
    queue_req(FN_LIST, 16'($urandom), pick_limit());
    queue_req(FN_FIRST, 16'($urandom), pick_limit());
  endtask

  task automatic drain_episode();
    logic [15:0] order [POOL_SIZE];
    shuffled_pool(order);
    for (int i = 0; i < POOL_SIZE; i++) begin
      queue_req(FN_REMOVE, order[i], pick_limit());
      if ($urandom_range(0, 5) == 0) queue_req(FN_CONTAINS, order[i], pick_limit());
    end
    queue_req(FN_FIRST, '0, pick_limit());
    queue_req(FN_LIST, '0, pick_limit());
  endtask

  task automatic mixed_episode();
    int roll;
    for (int i = 0; i < 12; i++) begin
      roll = $urandom_range(0, 99);
      if      (roll < 30) queue_req(FN_ADD,      pick_id(), pick_limit());
      else if (roll < 55) queue_req(FN_REMOVE,   pick_id(), pick_limit());
      else if (roll < 75) queue_req(FN_CONTAINS, pick_id(), pick_limit());
      else if (roll < 85) queue_req(FN_FIRST,    pick_id(), pick_limit());
      else if (roll < 95) queue_req(FN_LIST,     pick_id(), pick_limit());
      else queue_req(3'($urandom_range(FN_RSVD_LO, FN_RSVD_HI)), pick_id(), pick_limit());
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------
  initial forever #4 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Far beyond the slowest correct run (all list words, longest stalls).
  initial begin
    #2_000_000;
    $display("** fixed_capacity_id_set: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: one request word at a time, with random idle bursts
  // ---------------------------------------------------------------------
  set_req_t live_req;
  int       in_idle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_set_op(live_req);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_idle > 0) begin
          in_idle--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!in_tail() && $urandom_range(0, 99) < 30) begin
          // start an idle burst; it may chain with the next roll
          in_idle = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else begin
          live_req = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_DATA_W'({live_req.limit, live_req.id});
          in_tuser  <= live_req.op;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: back-pressure in bursts and per-word check
  // ---------------------------------------------------------------------
  set_reply_t got_reply;
  set_reply_t want_reply;
  int         out_stall = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_reply.status = out_tuser[0];
        got_reply.found  = out_tuser[1];
        got_reply.id_out = out_tdata[15:0];
        got_reply.count  = out_tdata[20:16];
        got_reply.full   = out_tdata[21];
        got_reply.empty  = out_tdata[22];
        got_reply.last   = out_tlast;
        n_replies++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word st=%b fd=%b id=%h cnt=%0d f=%b e=%b l=%b", $realtime,
                     got_reply.status, got_reply.found, got_reply.id_out, got_reply.count,
                     got_reply.full, got_reply.empty, got_reply.last);
        end else begin
          want_reply = expected_replies.pop_front();
          if (want_reply.found && want_reply.id_out != '0) n_list_words++;
          if (got_reply !== want_reply) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word %0d mismatch", $realtime, n_replies);
              $display("  exp st=%b fd=%b id=%h cnt=%0d f=%b e=%b l=%b",
                       want_reply.status, want_reply.found, want_reply.id_out, want_reply.count,
                       want_reply.full, want_reply.empty, want_reply.last);
              $display("  got st=%b fd=%b id=%h cnt=%0d f=%b e=%b l=%b",
                       got_reply.status, got_reply.found, got_reply.id_out, got_reply.count,
                       got_reply.full, got_reply.empty, got_reply.last);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 99) < 25) begin
        out_stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_id[i]   = '0;
      shadow_busy[i] = 1'b0;
    end
    // distinct, nonzero pool ids
    for (int i = 0; i < POOL_SIZE; i++)
      id_pool[i] = {11'($urandom_range(0, 2047)), 5'(i + 1)};

    // Directed: empty-table corners, empty id, dups, list limits, bad ops.
    queue_req(FN_FIRST,    '0,       5'd0);
    queue_req(FN_LIST,     '0,       5'(SLOTS));
    queue_req(FN_ADD,      '0,       5'd0);
    queue_req(FN_REMOVE,   '0,       5'd0);
    queue_req(FN_CONTAINS, '0,       5'd0);
    queue_req(FN_REMOVE,   16'h1234, 5'd0);
    queue_req(FN_ADD,      16'hFFFF, 5'd31);
    queue_req(FN_ADD,      16'h0001, 5'd0);
    queue_req(FN_ADD,      16'hFFFF, 5'd0);
    queue_req(FN_CONTAINS, 16'hFFFF, 5'd0);
    queue_req(FN_CONTAINS, 16'h00FF, 5'd0);
    queue_req(FN_LIST,     '0,       5'd0);
    queue_req(FN_LIST,     16'hFFFF, 5'd31);
    queue_req(FN_LIST,     '0,       5'd1);
    queue_req(FN_FIRST,    '0,       5'd0);
    queue_req(FN_REMOVE,   16'hFFFF, 5'd0);
    queue_req(FN_FIRST,    '0,       5'd0);   // lowest used slot is now slot 1
    queue_req(FN_ADD,      16'h8000, 5'd0);   // reuses freed slot 0
    queue_req(FN_LIST,     '0,       5'(SLOTS));
    for (int op = FN_RSVD_LO; op <= FN_RSVD_HI; op++)
      queue_req(3'(op), 16'hFFFF, 5'd31);
    queue_req(FN_REMOVE,   16'h0001, 5'd0);
    queue_req(FN_REMOVE,   16'h8000, 5'd0);

    // Random: fill to full, then churn, then drain; episodes mixed after.
    fill_episode();
    mixed_episode();
    drain_episode();
    while (pending_requests.size() < 195) begin
      case ($urandom_range(0, 5))
        0:       fill_episode();
        1:       drain_episode();
        default: mixed_episode();
      endcase
    end
    n_planned = pending_requests.size();

    @(posedge rst_n);
    while (n_accepted < n_planned || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests, %0d reply words (%0d carried ids), %0d refused.",
             n_accepted, n_replies, n_list_words, n_refused);
    $display("Table filled to capacity %0d times; %0d mismatching words.",
             n_full_hits, mismatches);
    if (mismatches == 0) begin
      $display("** fixed_capacity_id_set: PASSED **");
    end else begin
      $display("** fixed_capacity_id_set: FAILED **");
    end
    $finish;
  end

endmodule
